@@ rtl/core/kms_pkg.sv @@
// kms_pkg: shared types, constants and the key legend for the keypad matrix scanner.
// No dependencies; used by all rtl/core modules.
`timescale 1ns / 1ps

package kms_pkg;

	localparam int NUM_ROWS     = 4;
	localparam int NUM_COLS     = 4;
	localparam int NUM_KEYS     = NUM_ROWS * NUM_COLS;
	localparam int COL_BITS     = 2;
	localparam int CFG_BITS     = 9;
	localparam int CFG_IDX_BITS = 2;
	localparam int KEY_BITS     = 7;
	localparam int CNT_BITS_DEF = 9;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [CFG_BITS-1:0] PASSES_RST = 9'd400;
	localparam logic [CFG_BITS-1:0] THRESH_RST = 9'd300;

	// register indexes on the config port
	localparam logic [CFG_IDX_BITS-1:0] REG_PASSES = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESH = 2'd1;

	localparam logic [KEY_BITS-1:0] KEY_NONE = 7'd0;

	// per-lane control, one word per strobe
	typedef struct packed {
		logic                strobe;
		logic [COL_BITS-1:0] column;
		logic                refresh;
	} lane_ctrl_t;

	// state snapshot handed to the merge stage
	typedef struct packed {
		logic                valid;
		logic [COL_BITS-1:0] column;
		logic                refresh;
		logic [NUM_KEYS-1:0] held;
		logic [NUM_KEYS-1:0] prev;
	} snap_t;

	// one result word
	typedef struct packed {
		logic [COL_BITS-1:0] drive_column;
		logic                refresh_done;
		logic [KEY_BITS-1:0] held_key;
		logic [KEY_BITS-1:0] pressed_key;
		logic [KEY_BITS-1:0] released_key;
		logic [NUM_KEYS-1:0] key_map;
	} result_t;

	// legend "123A" / "456B" / "789C" / "*0#D", index row*4+column
	function automatic logic [KEY_BITS-1:0] key_ascii(input logic [3:0] idx);
		logic [KEY_BITS-1:0] a;
		begin
			unique case (idx)
				4'd0:    a = 7'h31; // '1'
				4'd1:    a = 7'h32; // '2'
				4'd2:    a = 7'h33; // '3'
				4'd3:    a = 7'h41; // 'A'
				4'd4:    a = 7'h34; // '4'
				4'd5:    a = 7'h35; // '5'
				4'd6:    a = 7'h36; // '6'
				4'd7:    a = 7'h42; // 'B'
				4'd8:    a = 7'h37; // '7'
				4'd9:    a = 7'h38; // '8'
				4'd10:   a = 7'h39; // '9'
				4'd11:   a = 7'h43; // 'C'
				4'd12:   a = 7'h2A; // '*'
				4'd13:   a = 7'h30; // '0'
				4'd14:   a = 7'h23; // '#'
				default: a = 7'h44; // 'D'
			endcase
			return a;
		end
	endfunction

	// lowest set bit wins; none gives KEY_NONE
	function automatic logic [KEY_BITS-1:0] first_key(input logic [NUM_KEYS-1:0] map);
		logic [KEY_BITS-1:0] k;
		begin
			k = KEY_NONE;
			for (int b = NUM_KEYS - 1; b >= 0; b--) begin
				if (map[b]) begin
					k = key_ascii(4'(b));
				end
			end
			return k;
		end
	endfunction

endpackage

@@ rtl/core/keypad_matrix_scanner.sv @@
// keypad_matrix_scanner: 4x4 key matrix scanner top level.
// Depends on kms_pkg, kms_row_lane and kms_merge.
`timescale 1ns / 1ps

// Channel | handshake            | payload
// --------+----------------------+--------------------------------------------
// in      | in_valid / in_ready  | row_levels[3:0]
// out     | out_valid / out_ready| drive_column, refresh_done, held_key,
//         |                      | pressed_key, released_key, key_map
// cfg     | cfg_valid / cfg_ready| cfg_index[1:0], cfg_data[8:0]
//
// One word per clock sustained while the result queue has room; each word gives one
// result word, held in the snapshot register and then written to the merge queue.
// The four row lanes update their counters in the accept cycle, so the next
// word may follow at once; only the 4-entry result queue limits throughput.
// Reset brings counters, column, pass count and maps to zero with no sweep;
// registers return to 400 passes and threshold 300.
// With out_ready low, in_ready drops once queued plus in-flight words reach 3.

module keypad_matrix_scanner
	import kms_pkg::*;
#(
	parameter int COUNTER_BITS = CNT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [3:0]              row_levels,

	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [COL_BITS-1:0]     drive_column,
	output logic                    refresh_done,
	output logic [KEY_BITS-1:0]     held_key,
	output logic [KEY_BITS-1:0]     pressed_key,
	output logic [KEY_BITS-1:0]     released_key,
	output logic [NUM_KEYS-1:0]     key_map,

	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	logic [CFG_BITS-1:0] passes_q;
	logic [CFG_BITS-1:0] thresh_q;

	logic [COL_BITS-1:0] column_q;
	logic [CFG_BITS-1:0] pass_q;
	logic [NUM_KEYS-1:0] held_q;
	logic [NUM_KEYS-1:0] prev_q;

	logic                accept;
	logic                room;
	logic                wrap;
	logic [COL_BITS-1:0] column_nxt;
	logic [CFG_BITS-1:0] pass_inc;
	logic [CFG_BITS-1:0] target;
	logic                refresh;
	logic [NUM_KEYS-1:0] lane_map;
	lane_ctrl_t          lane_ctrl;
	snap_t               snap;
	result_t             out_word;

	// config: always ready, unknown indexes dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			passes_q <= PASSES_RST;
			thresh_q <= THRESH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PASSES: passes_q <= cfg_data;
				REG_THRESH: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = room;
	assign accept   = in_valid && in_ready;

	// pass bookkeeping; zero passes acts as one
	assign column_nxt = column_q + 1'b1;
	assign wrap       = (column_q == COL_BITS'(NUM_COLS - 1));
	assign pass_inc   = pass_q + 1'b1;
	assign target     = (passes_q == '0) ? CFG_BITS'(1) : passes_q;
	assign refresh    = wrap && (pass_inc >= target);

	assign lane_ctrl.strobe  = accept;
	assign lane_ctrl.column  = column_q;
	assign lane_ctrl.refresh = refresh;

	// one lane per row; lane r owns keys r*4 .. r*4+3
	for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
		kms_row_lane #(
			.COUNTER_BITS(COUNTER_BITS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (lane_ctrl),
			.row_bit  (row_levels[r]),
			.threshold(thresh_q),
			.row_map  (lane_map[r*NUM_COLS +: NUM_COLS])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			pass_q   <= '0;
			held_q   <= '0;
			prev_q   <= '0;
		end else if (accept) begin
			column_q <= column_nxt;
			if (refresh) begin
				pass_q <= '0;
				prev_q <= held_q;
				held_q <= lane_map;
			end else if (wrap) begin
				pass_q <= pass_inc;
			end
		end
	end

	// post-update state goes to the merge stage
	assign snap.valid   = accept;
	assign snap.column  = column_nxt;
	assign snap.refresh = refresh;
	assign snap.held    = refresh ? lane_map : held_q;
	assign snap.prev    = refresh ? held_q : prev_q;

	kms_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.snap     (snap),
		.room     (room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	assign drive_column = out_word.drive_column;
	assign refresh_done = out_word.refresh_done;
	assign held_key     = out_word.held_key;
	assign pressed_key  = out_word.pressed_key;
	assign released_key = out_word.released_key;
	assign key_map      = out_word.key_map;

endmodule

@@ rtl/core/kms_row_lane.sv @@
// kms_row_lane: hit counters of one keypad row, one per column, with threshold check.
// Depends on kms_pkg.
`timescale 1ns / 1ps

module kms_row_lane
	import kms_pkg::*;
#(
	parameter int COUNTER_BITS = CNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lane_ctrl_t          ctrl,
	input  logic                row_bit,
	input  logic [CFG_BITS-1:0] threshold,
	output logic [NUM_COLS-1:0] row_map
);

	localparam int CMP_BITS = (COUNTER_BITS > CFG_BITS) ? COUNTER_BITS : CFG_BITS;
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

	logic [COUNTER_BITS-1:0] cnt_q   [NUM_COLS];
	logic [COUNTER_BITS-1:0] cnt_nxt [NUM_COLS];

	// saturating increment of the driven column, then compare the updated count
	always_comb begin
		for (int c = 0; c < NUM_COLS; c++) begin
			cnt_nxt[c] = cnt_q[c];
			if (ctrl.strobe && row_bit && (ctrl.column == COL_BITS'(c)) &&
				(cnt_q[c] != CNT_MAX)) begin
				cnt_nxt[c] = cnt_q[c] + 1'b1;
			end
			row_map[c] = (CMP_BITS'(cnt_nxt[c]) >= CMP_BITS'(threshold));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				cnt_q[c] <= '0;
			end
		end else if (ctrl.strobe) begin
			for (int c = 0; c < NUM_COLS; c++) begin
				cnt_q[c] <= ctrl.refresh ? '0 : cnt_nxt[c];
			end
		end
	end

endmodule

@@ rtl/core/kms_merge.sv @@
// kms_merge: registers the map snapshot, finds first held/pressed/released keys,
// and queues result words. Depends on kms_pkg.
`timescale 1ns / 1ps

module kms_merge
	import kms_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  snap_t   snap,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_word
);

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	logic                valid_s1;
	logic [COL_BITS-1:0] column_s1;
	logic                refresh_s1;
	logic [NUM_KEYS-1:0] held_s1;
	logic [NUM_KEYS-1:0] prev_s1;

	result_t             queue_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	result_t enc;
	logic    pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= snap.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap.valid) begin
			column_s1  <= snap.column;
			refresh_s1 <= snap.refresh;
			held_s1    <= snap.held;
			prev_s1    <= snap.prev;
		end
	end

	always_comb begin
		enc.drive_column = column_s1;
		enc.refresh_done = refresh_s1;
		enc.held_key     = first_key(held_s1);
		enc.pressed_key  = first_key(held_s1 & ~prev_s1);
		enc.released_key = first_key(prev_s1 & ~held_s1);
		enc.key_map      = held_s1;
	end

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_word  = queue_q[rd_ptr_q];

	// leave space for the word in s1 plus one more
	assign room = ((count_q + CNT_BITS'(valid_s1)) < CNT_BITS'(QUEUE_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_BITS'(valid_s1) - CNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			queue_q[wr_ptr_q] <= enc;
		end
	end

endmodule
